// ===== hdl/aqmh_pkg.sv =====
// ----------------------------------------------------------------------------
// aqmh_pkg
// Shared types and constants of the bounded array queue with running maximum.
// ----------------------------------------------------------------------------
`default_nettype none

package aqmh_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FuncW = 2;
  localparam int unsigned FillW = 5;

  // command codes
  typedef enum logic [FuncW-1:0] {
    FuncEnq  = 2'd0,
    FuncInv  = 2'd1,
    FuncDisp = 2'd2
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StFew   = 2'd2,
    StEmpty = 2'd3
  } status_e;

  // one result word
  typedef struct packed {
    status_e                  status;
    logic signed [DataW-1:0]  element;
    logic                     last;
    logic signed [DataW-1:0]  max_value;
    logic                     max_valid;
    logic        [FillW-1:0]  fill_level;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/aqmh_if.sv =====
// ----------------------------------------------------------------------------
// aqmh_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface aqmh_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic signed [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface aqmh_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] element;
  logic        last;
  logic signed [31:0] max_value;
  logic        max_valid;
  logic [4:0]  fill_level;

  modport source (output valid, output status, output element, output last,
                  output max_value, output max_valid, output fill_level,
                  input ready);
  modport sink   (input valid, input status, input element, input last,
                  input max_value, input max_valid, input fill_level,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/array_queue_max_half_reverse_top.sv =====
// ----------------------------------------------------------------------------
// array_queue_max_half_reverse_top
// Bounded append-only queue with running maximum, half reversal and display.
// ----------------------------------------------------------------------------
// Each command word gives one or more result words. Enqueue, a rejected
// command and the unused code load their one result word at once.
// Invert-half swaps the held entries pair by pair (read low, read high,
// write low, write high on the entry store), and its status word goes out
// at once. Display first issues the read of entry 0, then streams one
// entry per cycle while the result side keeps taking words. The entry
// store is not cleared at reset; only entries below the fill count are ever
// read. An output register lets a finished word wait while the sequencer
// goes on with a swap walk; a new command or display word waits for it.
`default_nettype none

module array_queue_max_half_reverse_top
  import aqmh_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  aqmh_cmd_if.sink        cmd_i,
  aqmh_res_if.source      res_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  // entry store port
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [DataW-1:0] mem_rdata;

  // result register
  logic             res_valid_q;
  res_t             res_q;
  res_t             res_new;
  logic             res_load;
  logic             res_free;

  // the register may take a new word when empty or being drained
  assign res_free = !res_valid_q || res_o.ready;

  aqmh_ctrl #(
    .Depth (DEPTH),
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .cmd_func_i  (cmd_i.func),
    .cmd_value_i (cmd_i.value),
    .res_free_i  (res_free),
    .res_load_o  (res_load),
    .res_o       (res_new),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  aqmh_mem #(
    .Depth (DEPTH),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_new;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.status     = res_q.status;
  assign res_o.element    = res_q.element;
  assign res_o.last       = res_q.last;
  assign res_o.max_value  = res_q.max_value;
  assign res_o.max_valid  = res_q.max_valid;
  assign res_o.fill_level = res_q.fill_level;

endmodule

`default_nettype wire

// ===== hdl/aqmh_mem.sv =====
// ----------------------------------------------------------------------------
// aqmh_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aqmh_mem
  import aqmh_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/aqmh_ctrl.sv =====
// ----------------------------------------------------------------------------
// aqmh_ctrl
// Command sequencer: fill count, running maximum, swap and stream walks.
// ----------------------------------------------------------------------------
`default_nettype none

module aqmh_ctrl
  import aqmh_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned CntW  = $clog2(Depth + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // command word
  input  wire logic                     cmd_valid_i,
  output      logic                     cmd_ready_o,
  input  wire logic [FuncW-1:0]         cmd_func_i,
  input  wire logic signed [DataW-1:0]  cmd_value_i,
  // result register
  input  wire logic                     res_free_i,
  output      logic                     res_load_o,
  output      res_t                     res_o,
  // entry store
  output      logic                     mem_we_o,
  output      logic [AddrW-1:0]         mem_waddr_o,
  output      logic [DataW-1:0]         mem_wdata_o,
  output      logic                     mem_re_o,
  output      logic [AddrW-1:0]         mem_raddr_o,
  input  wire logic [DataW-1:0]         mem_rdata_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRdLo  = 3'd1;
  localparam logic [2:0] StRdHi  = 3'd2;
  localparam logic [2:0] StWrLo  = 3'd3;
  localparam logic [2:0] StWrHi  = 3'd4;
  localparam logic [2:0] StDisp  = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [CntW-1:0]         count_q, count_d;
  logic signed [DataW-1:0] max_q, max_d;
  logic [AddrW-1:0]        lo_q, lo_d;
  logic [AddrW-1:0]        hi_q, hi_d;
  logic [AddrW-1:0]        idx_q, idx_d;
  logic [DataW-1:0]        tmp_q, tmp_d;

  logic                    accept;
  logic [CntW-1:0]         cnt_m1;
  logic [AddrW-1:0]        hi_start;
  logic [CntW+FillW-1:0]   cnt_ext;
  logic [CntW+FillW-1:0]   cnt_inc_ext;
  logic [FillW-1:0]        fill_cur;
  logic [FillW-1:0]        fill_inc;
  logic signed [DataW-1:0] max_cur;
  logic signed [DataW-1:0] max_enq;
  logic                    disp_last;
  logic                    swap_more;

  // result that reports the current fill and maximum
  function automatic res_t mk_res(status_e st, logic [DataW-1:0] elem, logic lst,
                                  logic signed [DataW-1:0] mx, logic mv,
                                  logic [FillW-1:0] fl);
    res_t r;
    r.status     = st;
    r.element    = elem;
    r.last       = lst;
    r.max_value  = mx;
    r.max_valid  = mv;
    r.fill_level = fl;
    return r;
  endfunction

  assign cmd_ready_o = (state_q == StIdle) && res_free_i;
  assign accept      = cmd_valid_i && cmd_ready_o;

  assign cnt_m1      = count_q - 1'b1;
  assign hi_start    = AddrW'(cnt_m1 >> 1);
  assign cnt_ext     = {{FillW{1'b0}}, count_q};
  assign cnt_inc_ext = {{FillW{1'b0}}, count_q + 1'b1};
  assign fill_cur    = cnt_ext[FillW-1:0];
  assign fill_inc    = cnt_inc_ext[FillW-1:0];
  assign max_cur     = (count_q != '0) ? max_q : '0;
  assign max_enq     = ((count_q == '0) || (cmd_value_i > max_q)) ? cmd_value_i : max_q;
  assign disp_last   = (CntW'(idx_q) + 1'b1) == count_q;
  // another pair remains when lo + 1 < hi - 1
  assign swap_more   = ({1'b0, lo_q} + (AddrW+1)'(2)) < {1'b0, hi_q};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    max_d       = max_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    idx_d       = idx_q;
    tmp_d       = tmp_q;
    res_load_o  = 1'b0;
    res_o       = mk_res(StOk, '0, 1'b1, max_cur, count_q != '0, fill_cur);
    mem_we_o    = 1'b0;
    mem_waddr_o = lo_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = lo_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          res_load_o = 1'b1;
          unique case (cmd_func_i)
            FuncEnq: begin
              if (count_q >= CntW'(Depth)) begin
                res_o = mk_res(StFull, '0, 1'b1, max_cur, count_q != '0, fill_cur);
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = count_q[AddrW-1:0];
                mem_wdata_o = cmd_value_i;
                max_d       = max_enq;
                count_d     = count_q + 1'b1;
                res_o       = mk_res(StOk, '0, 1'b1, max_enq, 1'b1, fill_inc);
              end
            end
            FuncInv: begin
              if (count_q < CntW'(2)) begin
                res_o = mk_res(StFew, '0, 1'b1, max_cur, count_q != '0, fill_cur);
              end else begin
                // order is fixed, so the status goes out now
                lo_d = '0;
                hi_d = hi_start;
                if (hi_start != '0) begin
                  state_d = StRdLo;
                end
              end
            end
            FuncDisp: begin
              if (count_q == '0) begin
                res_o = mk_res(StEmpty, '0, 1'b1, max_cur, 1'b0, fill_cur);
              end else begin
                res_load_o  = 1'b0;
                mem_re_o    = 1'b1;
                mem_raddr_o = '0;
                idx_d       = '0;
                state_d     = StDisp;
              end
            end
            default: ;
          endcase
        end
      end
      StRdLo: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = lo_q;
        state_d     = StRdHi;
      end
      StRdHi: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = hi_q;
        tmp_d       = mem_rdata_i;
        state_d     = StWrLo;
      end
      StWrLo: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = lo_q;
        mem_wdata_o = mem_rdata_i;
        state_d     = StWrHi;
      end
      StWrHi: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = hi_q;
        mem_wdata_o = tmp_q;
        lo_d        = lo_q + 1'b1;
        hi_d        = hi_q - 1'b1;
        state_d     = swap_more ? StRdLo : StIdle;
      end
      StDisp: begin
        if (res_free_i) begin
          res_load_o = 1'b1;
          res_o      = mk_res(StOk, mem_rdata_i, disp_last, max_cur, 1'b1, fill_cur);
          if (disp_last) begin
            state_d = StIdle;
          end else begin
            // next read lands as this word is taken
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_q + 1'b1;
            idx_d       = idx_q + 1'b1;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      max_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      max_q   <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    idx_q <= idx_d;
    tmp_q <= tmp_d;
  end

endmodule

`default_nettype wire
